FILE: hdl/rbd_pkg.sv
// shared types and constants for the run-length / back-reference byte decompressor
// no dependencies; imported by rbd_front, rbd_back and the top level
package rbd_pkg;

  localparam int ADDR_BITS_DEF = 14;
  localparam int CMD_QUEUE_DEPTH = 2;

  // item op codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  // run modes
  localparam logic [2:0] MODE_INLINE = 3'd0;
  localparam logic [2:0] MODE_RLE    = 3'd1;
  localparam logic [2:0] MODE_RLE16  = 3'd2;
  localparam logic [2:0] MODE_RLE24  = 3'd3;
  localparam logic [2:0] MODE_RLE32  = 3'd4;

  // header type, top three bits of a header byte
  localparam logic [2:0] HT_RLE    = 3'b010;
  localparam logic [2:0] HT_RLE32  = 3'b011;
  localparam logic [2:0] HT_RLE16  = 3'b100;
  localparam logic [2:0] HT_RLE24  = 3'b101;
  localparam logic [2:0] HT_BREF_A = 3'b110;
  localparam logic [2:0] HT_BREF_B = 3'b111;

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_stream;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] address;
    logic [7:0]  data;
  } cmd_t;

endpackage

FILE: hdl/rbd_ram.sv
// generic single-port ram, one access per cycle, registered read data
// no dependencies
module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/rbd_front.sv
// front end: accepts input transactions, drops unused op codes and queues commands
// depends on rbd_pkg
module rbd_front
  import rbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  localparam int PTR_BITS = $clog2(CMD_QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t                q_r [CMD_QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                accept;
  logic                enq;
  logic                deq;
  cmd_t                new_cmd;

  assign full   = (count_r == CNT_BITS'(CMD_QUEUE_DEPTH));
  assign accept = push && !full;

  always_comb begin
    new_cmd.kind    = in_item.op;
    new_cmd.address = in_item.address;
    new_cmd.data    = in_item.data;
    case (in_item.op)
      OP_LOAD, OP_START, OP_FETCH: enq = accept;
      default:                     enq = 1'b0;
    endcase
  end

  assign deq       = cmd_pop && (count_r != '0);
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (enq && !deq) begin
      count_nxt = count_r + 1'b1;
    end else if (deq && !enq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

FILE: hdl/rbd_back.sv
// back end: executes queued commands against the compressed store, owns the
// stream decoder state and the output register; depends on rbd_pkg
module rbd_back
  import rbd_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  output logic                 ram_we,
  output logic                 ram_re,
  output logic [ADDR_BITS-1:0] ram_addr,
  output logic [7:0]           ram_wdata,
  input  logic [7:0]           ram_rdata,
  input  logic                 pop,
  output logic                 empty,
  output out_item_t            out_item
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_OFF1 = 3'd2;
  localparam logic [2:0] ST_OFF2 = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;
  localparam logic [2:0] ST_DATA = 3'd5;
  localparam logic [2:0] ST_END  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [ADDR_BITS-1:0] sp_r, sp_nxt;
  logic [ADDR_BITS-1:0] cp_r, cp_nxt;
  logic [7:0]           rem_r, rem_nxt;
  logic [2:0]           mode_r, mode_nxt;
  logic                 ended_r, ended_nxt;
  logic [7:0]           hdr_r, hdr_nxt;
  logic [7:0]           off_hi_r, off_hi_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic                 out_free;
  logic                 out_load;
  logic [ADDR_BITS+13:0] cmd_addr_ext;
  logic [ADDR_BITS-1:0] cmd_addr;
  logic [ADDR_BITS-1:0] group_back;
  logic [ADDR_BITS-1:0] run_addr;
  logic [ADDR_BITS-1:0] run_cp;
  logic [15:0]          off16;
  logic [7:0]           grp_base;
  logic [7:0]           inl_cnt;

  // store address from the 14-bit item field, extended or wrapped
  assign cmd_addr_ext = {ADDR_BITS'(0), cmd.address};
  assign cmd_addr     = cmd_addr_ext[ADDR_BITS-1:0];

  // one run byte: group runs step back a group when they catch up with the stream
  always_comb begin
    case (mode_r)
      MODE_RLE16: group_back = ADDR_BITS'(2);
      MODE_RLE24: group_back = ADDR_BITS'(3);
      MODE_RLE32: group_back = ADDR_BITS'(4);
      default:    group_back = '0;
    endcase
    if (group_back != '0 && cp_r == sp_r) begin
      run_addr = cp_r - group_back;
    end else begin
      run_addr = cp_r;
    end
    run_cp = (mode_r == MODE_RLE) ? cp_r : run_addr + 1'b1;
  end

  assign off16    = {off_hi_r, ram_rdata};
  assign grp_base = 8'(ram_rdata[4:0]) + 8'd2;
  assign inl_cnt  = 8'(ram_rdata[5:0]) + 8'd1;
  assign out_free = !out_valid_r || pop;

  always_comb begin
    state_nxt  = state_r;
    sp_nxt     = sp_r;
    cp_nxt     = cp_r;
    rem_nxt    = rem_r;
    mode_nxt   = mode_r;
    ended_nxt  = ended_r;
    hdr_nxt    = hdr_r;
    off_hi_nxt = off_hi_r;
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = sp_r;
    ram_wdata  = cmd.data;
    out_load   = 1'b0;
    out_nxt    = out_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            OP_LOAD: begin
              ram_we   = 1'b1;
              ram_addr = cmd_addr;
            end
            OP_START: begin
              sp_nxt    = cmd_addr;
              cp_nxt    = '0;
              rem_nxt   = '0;
              mode_nxt  = MODE_INLINE;
              ended_nxt = 1'b0;
            end
            OP_FETCH: begin
              if (ended_r) begin
                state_nxt = ST_END;
              end else if (rem_r == 8'd0) begin
                ram_re    = 1'b1;
                ram_addr  = sp_r;
                sp_nxt    = sp_r + 1'b1;
                state_nxt = ST_HDR;
              end else begin
                ram_re    = 1'b1;
                ram_addr  = run_addr;
                cp_nxt    = run_cp;
                rem_nxt   = rem_r - 8'd1;
                state_nxt = ST_DATA;
              end
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        hdr_nxt   = ram_rdata;
        state_nxt = ST_RUN;
        case (ram_rdata[7:5])
          HT_BREF_A, HT_BREF_B: begin
            ram_re    = 1'b1;
            ram_addr  = sp_r;
            state_nxt = ST_OFF1;
          end
          HT_RLE32: begin
            mode_nxt = MODE_RLE32;
            cp_nxt   = sp_r;
            sp_nxt   = sp_r + ADDR_BITS'(4);
            rem_nxt  = grp_base << 2;
          end
          HT_RLE24: begin
            mode_nxt = MODE_RLE24;
            cp_nxt   = sp_r;
            sp_nxt   = sp_r + ADDR_BITS'(3);
            rem_nxt  = (grp_base << 1) + grp_base;
          end
          HT_RLE16: begin
            mode_nxt = MODE_RLE16;
            cp_nxt   = sp_r;
            sp_nxt   = sp_r + ADDR_BITS'(2);
            rem_nxt  = grp_base << 1;
          end
          HT_RLE: begin
            mode_nxt = MODE_RLE;
            cp_nxt   = sp_r;
            sp_nxt   = sp_r + 1'b1;
            rem_nxt  = 8'(ram_rdata[4:0]) + 8'd3;
          end
          default: begin
            mode_nxt = MODE_INLINE;
            cp_nxt   = sp_r;
            sp_nxt   = sp_r + ADDR_BITS'(inl_cnt);
            rem_nxt  = inl_cnt;
          end
        endcase
      end
      ST_OFF1: begin
        off_hi_nxt = ram_rdata;
        ram_re     = 1'b1;
        ram_addr   = sp_r + 1'b1;
        state_nxt  = ST_OFF2;
      end
      ST_OFF2: begin
        if (off16 == 16'd0) begin
          ended_nxt = 1'b1;
          state_nxt = ST_END;
        end else begin
          mode_nxt  = MODE_INLINE;
          cp_nxt    = sp_r + off16[ADDR_BITS-1:0];
          sp_nxt    = sp_r + ADDR_BITS'(2);
          rem_nxt   = 8'(hdr_r[5:0]) + 8'd4;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ram_re    = 1'b1;
        ram_addr  = run_addr;
        cp_nxt    = run_cp;
        rem_nxt   = rem_r - 8'd1;
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_nxt.out_byte      = ram_rdata;
          out_nxt.end_of_stream = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end
      ST_END: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_nxt.out_byte      = 8'd0;
          out_nxt.end_of_stream = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_r        <= '0;
      cp_r        <= '0;
      rem_r       <= '0;
      mode_r      <= MODE_INLINE;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      cp_r        <= cp_nxt;
      rem_r       <= rem_nxt;
      mode_r      <= mode_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r    <= hdr_nxt;
    off_hi_r <= off_hi_nxt;
    out_r    <= out_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

endmodule

FILE: hdl/rle_backref_byte_decompressor.sv
// top level of the run-length / back-reference byte decompressor
// depends on rbd_pkg, rbd_ram, rbd_front, rbd_back
//
//   channel   direction  handshake        payload
//   input     in         push / full      in_item  (op, address, data)
//   result    out        empty / pop      out_item (out_byte, end_of_stream)
//
// the back end uses the single store port once per cycle. load and start: idle;
// a fetch inside a run: idle, data; one that opens a run: idle, header, run, data;
// one opening a back ref: idle, header, off1, off2, run, data; ended: idle, end.
// reset clears decoder and queue state only; store contents are undefined until loaded.
// a two-entry command queue accepts, until full, while the back end works or while
// a result waits in the output register; the back end holds until it is taken.
module rle_backref_byte_decompressor
  import rbd_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic                 cmd_valid;
  cmd_t                 cmd;
  logic                 cmd_pop;
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  rbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  rbd_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

  rbd_ram #(
    .WIDTH (8),
    .DEPTH (1 << ADDR_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // an end-of-stream transaction always carries a zero byte
  a_eos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.end_of_stream) |-> (out_item.out_byte == 8'd0))
    else $error("end of stream with nonzero byte");

  // the store port is either written or read in a cycle, never both
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read in one cycle");

  // commands only leave the queue when one is present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> empty)
    else $error("result pending after reset");

endmodule
